FILE: rtl/gwwj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word wrap package
// Types, constants and saturating helpers shared by the word wrap block.
// ----------------------------------------------------------------------------
package gwwj_pkg;

   // Text size and the highest byte offset that the position counter reaches.
   localparam int unsigned TEXT_BYTES = 65536;
   localparam logic [15:0] POS_MAX =
      (TEXT_BYTES - 1 < 65535) ? 16'(TEXT_BYTES - 1) : 16'hFFFF;

   // Byte codes with a meaning of their own.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;

   // Saturation limits.
   localparam logic [16:0] VERT_MAX = 17'd131070;

   // Configuration port.
   localparam int CSR_DATA_WIDTH = 12;

   typedef enum logic [0:0] {
      CSR_LINE_WIDTH,
      CSR_SPACE_ADVANCE
   } csr_index_type;

   // Serial divider: one quotient bit per step.
   localparam int DIVIDEND_WIDTH = 20;
   localparam int DIVISOR_WIDTH  = 16;
   localparam int DIV_CNT_WIDTH  = $clog2(DIVIDEND_WIDTH);
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(DIVIDEND_WIDTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_CHECK,
      ST_DIVIDE,
      ST_WRAP,
      ST_BREAK,
      ST_NEWLINE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic accum;
      logic div_start;
      logic wrap;
      logic brk;
      logic nl;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_nl;
      logic is_print;
      logic over;
      logic has_space;
      logic multi_glyph;
      logic slot_free;
      logic div_busy;
   } status_type;

   // Saturating 16-bit add.
   function automatic logic [15:0] sat_add16(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // Vertex count plus two, saturating.
   function automatic logic [16:0] sat_vert(logic [16:0] a);
      logic [17:0] s;
      s = {1'b0, a} + 18'd2;
      return (s > {1'b0, VERT_MAX}) ? VERT_MAX : s[16:0];
   endfunction

   // X position plus an advance, saturating at the top of 20 bits.
   function automatic logic [19:0] sat_x(logic [19:0] a, logic [7:0] b);
      logic [20:0] s;
      s = {1'b0, a} + {13'd0, b};
      return s[20] ? 20'hFFFFF : s[19:0];
   endfunction

endpackage

FILE: rtl/gwwj_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word wrap channels
// Valid/ready channels for text bytes, line records and register writes.
// ----------------------------------------------------------------------------
interface gwwj_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic [7:0] char_advance;
   logic       text_start;

   modport source(output valid, output char_byte, output char_advance,
                  output text_start, input ready);
   modport sink(input valid, input char_byte, input char_advance,
                input text_start, output ready);
endinterface

interface gwwj_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] line_start;
   logic [15:0] line_bytes;
   logic [16:0] vertex_count;
   logic [20:0] space_width_q8;
   logic        last_of_run;

   modport source(output valid, output line_start, output line_bytes,
                  output vertex_count, output space_width_q8,
                  output last_of_run, input ready);
   modport sink(input valid, input line_start, input line_bytes,
                input vertex_count, input space_width_q8,
                input last_of_run, output ready);
endinterface

interface gwwj_csr_if;
   logic                                   valid;
   logic                                   ready;
   gwwj_pkg::csr_index_type                index;
   logic [gwwj_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/gwwj_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word wrap serial divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gwwj_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [gwwj_pkg::DIVIDEND_WIDTH-1:0]  dividend,
   input  logic [gwwj_pkg::DIVISOR_WIDTH-1:0]   divisor,
   output logic                                 busy,
   output logic [gwwj_pkg::DIVIDEND_WIDTH-1:0]  quotient
);

   logic                                busy_ff, busy_in;
   logic [gwwj_pkg::DIV_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [gwwj_pkg::DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [gwwj_pkg::DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [gwwj_pkg::DIVISOR_WIDTH-1:0]  div_ff, div_in;
   logic [gwwj_pkg::DIVISOR_WIDTH:0]    trial;
   logic                                fits;

   // The next dividend bit enters the partial remainder; subtract if it fits.
   assign trial = {rem_ff, quo_ff[gwwj_pkg::DIVIDEND_WIDTH-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? gwwj_pkg::DIVISOR_WIDTH'(trial - {1'b0, div_ff})
                       : trial[gwwj_pkg::DIVISOR_WIDTH-1:0];
         quo_in = {quo_ff[gwwj_pkg::DIVIDEND_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == gwwj_pkg::DIV_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   // The divider stops after exactly one pass over the dividend bits.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == gwwj_pkg::DIV_LAST |=> !busy_ff)
      else $error("divider ran past its last step");

   // A start always makes the divider busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");

endmodule

FILE: rtl/gwwj_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word wrap datapath
// Line state, configuration registers, slack division and the record register.
// ----------------------------------------------------------------------------
module gwwj_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  gwwj_pkg::cmd_type                   cmd,
   output gwwj_pkg::status_type                sts,
   input  logic [7:0]                          req_char_byte,
   input  logic [7:0]                          req_char_advance,
   input  logic                                req_text_start,
   input  logic                                csr_write,
   input  gwwj_pkg::csr_index_type             csr_index,
   input  logic [gwwj_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [15:0]                         rsp_line_start,
   output logic [15:0]                         rsp_line_bytes,
   output logic [16:0]                         rsp_vertex_count,
   output logic [20:0]                         rsp_space_width_q8,
   output logic                                rsp_last_of_run
);

   // Configuration.
   logic [11:0] line_width_ff, line_width_in;
   logic [7:0]  space_advance_ff, space_advance_in;

   // Latched input byte.
   logic [7:0]  char_ff, char_in;
   logic [7:0]  adv_ff, adv_in;
   logic        start_ff, start_in;
   logic [15:0] item_pos_ff, item_pos_in;

   // Line state.
   logic [15:0] byte_position_ff, byte_position_in;
   logic        line_open_ff, line_open_in;
   logic [15:0] cur_start_ff, cur_start_in;
   logic [15:0] cur_bytes_ff, cur_bytes_in;
   logic [16:0] cur_vertices_ff, cur_vertices_in;
   logic [19:0] cur_x_ff, cur_x_in;
   logic [15:0] space_count_ff, space_count_in;
   logic [15:0] saved_bytes_ff, saved_bytes_in;
   logic [16:0] saved_vertices_ff, saved_vertices_in;
   logic [19:0] saved_x_ff, saved_x_in;
   logic [15:0] word_bytes_ff, word_bytes_in;
   logic [16:0] word_vertices_ff, word_vertices_in;
   logic [19:0] word_x_ff, word_x_in;

   // Record register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_start_ff, rsp_start_in;
   logic [15:0] rsp_bytes_ff, rsp_bytes_in;
   logic [16:0] rsp_vert_ff, rsp_vert_in;
   logic [20:0] rsp_sw_ff, rsp_sw_in;
   logic        rsp_last_ff, rsp_last_in;

   // Line state as seen by the byte being accumulated.
   logic        open_now;
   logic [15:0] pos_eff;
   logic [15:0] b_bytes, b_sc, b_saved_bytes, b_word_bytes;
   logic [16:0] b_vert, b_saved_vert, b_word_vert;
   logic [19:0] b_x, b_saved_x, b_word_x;

   logic        is_space, is_nl, is_print;
   logic [11:0] slack;
   logic [20:0] plain_sw;
   logic [20:0] wrap_sw;
   logic        div_busy;
   logic [19:0] quotient;
   logic        slot_free;

   assign is_space = char_ff == gwwj_pkg::CHAR_SPACE;
   assign is_nl    = char_ff == gwwj_pkg::CHAR_NEWLINE;
   assign is_print = char_ff > gwwj_pkg::CHAR_SPACE;

   // A text start clears everything; a closed line reopens at this byte.
   assign open_now      = start_ff | ~line_open_ff;
   assign pos_eff       = start_ff ? 16'd0 : byte_position_ff;
   assign b_bytes       = open_now ? 16'd0 : cur_bytes_ff;
   assign b_sc          = open_now ? 16'd0 : space_count_ff;
   assign b_saved_bytes = open_now ? 16'd0 : saved_bytes_ff;
   assign b_word_bytes  = open_now ? 16'd0 : word_bytes_ff;
   assign b_vert        = open_now ? 17'd0 : cur_vertices_ff;
   assign b_saved_vert  = open_now ? 17'd0 : saved_vertices_ff;
   assign b_word_vert   = open_now ? 17'd0 : word_vertices_ff;
   assign b_x           = open_now ? 20'd0 : cur_x_ff;
   assign b_saved_x     = open_now ? 20'd0 : saved_x_ff;
   assign b_word_x      = open_now ? 20'd0 : word_x_ff;

   // Slack of the line up to its last space, and the justified space width.
   assign slack    = ({8'd0, line_width_ff} > saved_x_ff)
                     ? 12'(({8'd0, line_width_ff}) - saved_x_ff) : 12'd0;
   assign plain_sw = {5'd0, space_advance_ff, 8'd0};
   assign wrap_sw  = plain_sw
                     + ((space_count_ff == 16'd1) ? 21'd0 : {1'b0, quotient});

   assign slot_free = ~rsp_valid_ff | rsp_ready;

   gwwj_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({slack, 8'd0}),
      .divisor  (space_count_ff - 16'd1),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Configuration writes.
   always_comb begin
      line_width_in    = line_width_ff;
      space_advance_in = space_advance_ff;
      if (csr_write) begin
         case (csr_index)
            gwwj_pkg::CSR_LINE_WIDTH:    line_width_in    = csr_data[11:0];
            gwwj_pkg::CSR_SPACE_ADVANCE: space_advance_in = csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Line state updates, one command at a time.
   always_comb begin
      char_in           = char_ff;
      adv_in            = adv_ff;
      start_in          = start_ff;
      item_pos_in       = item_pos_ff;
      byte_position_in  = byte_position_ff;
      line_open_in      = line_open_ff;
      cur_start_in      = cur_start_ff;
      cur_bytes_in      = cur_bytes_ff;
      cur_vertices_in   = cur_vertices_ff;
      cur_x_in          = cur_x_ff;
      space_count_in    = space_count_ff;
      saved_bytes_in    = saved_bytes_ff;
      saved_vertices_in = saved_vertices_ff;
      saved_x_in        = saved_x_ff;
      word_bytes_in     = word_bytes_ff;
      word_vertices_in  = word_vertices_ff;
      word_x_in         = word_x_ff;

      if (cmd.load) begin
         char_in  = req_char_byte;
         adv_in   = req_char_advance;
         start_in = req_text_start;
      end else if (cmd.accum) begin
         byte_position_in  = (pos_eff >= gwwj_pkg::POS_MAX) ? gwwj_pkg::POS_MAX
                                                            : pos_eff + 16'd1;
         item_pos_in       = pos_eff;
         line_open_in      = 1'b1;
         cur_start_in      = open_now ? pos_eff : cur_start_ff;
         cur_bytes_in      = gwwj_pkg::sat_add16(b_bytes, 16'd1);
         cur_vertices_in   = b_vert;
         cur_x_in          = b_x;
         space_count_in    = b_sc;
         saved_bytes_in    = b_saved_bytes;
         saved_vertices_in = b_saved_vert;
         saved_x_in        = b_saved_x;
         word_bytes_in     = b_word_bytes;
         word_vertices_in  = b_word_vert;
         word_x_in         = b_word_x;
         if (is_space) begin
            saved_x_in        = b_x;
            cur_x_in          = gwwj_pkg::sat_x(b_x, space_advance_ff);
            saved_bytes_in    = gwwj_pkg::sat_add16(b_bytes, 16'd1);
            saved_vertices_in = b_vert;
            space_count_in    = gwwj_pkg::sat_add16(b_sc, 16'd1);
            word_bytes_in     = 16'd0;
            word_vertices_in  = 17'd0;
            word_x_in         = 20'd0;
         end else if (is_print) begin
            cur_vertices_in  = gwwj_pkg::sat_vert(b_vert);
            cur_x_in         = gwwj_pkg::sat_x(b_x, adv_ff);
            word_bytes_in    = gwwj_pkg::sat_add16(b_word_bytes, 16'd1);
            word_vertices_in = gwwj_pkg::sat_vert(b_word_vert);
            word_x_in        = gwwj_pkg::sat_x(b_word_x, adv_ff);
         end else if (!is_nl) begin
            word_bytes_in = gwwj_pkg::sat_add16(b_word_bytes, 16'd1);
         end
      end else if (cmd.wrap) begin
         // The partial word after the last space carries into the new line.
         cur_start_in      = gwwj_pkg::sat_add16(cur_start_ff, saved_bytes_ff);
         cur_bytes_in      = word_bytes_ff;
         cur_vertices_in   = word_vertices_ff;
         cur_x_in          = word_x_ff;
         space_count_in    = 16'd0;
         saved_bytes_in    = 16'd0;
         saved_vertices_in = 17'd0;
         saved_x_in        = 20'd0;
      end else if (cmd.brk) begin
         // The overflowing byte opens the next line on its own.
         cur_start_in     = item_pos_ff;
         cur_bytes_in     = 16'd1;
         cur_vertices_in  = 17'd2;
         cur_x_in         = {12'd0, adv_ff};
         word_bytes_in    = 16'd1;
         word_vertices_in = 17'd2;
         word_x_in        = {12'd0, adv_ff};
      end else if (cmd.nl) begin
         line_open_in = 1'b0;
      end
   end

   // Record register: loaded by an emitting command, freed by a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_start_in = rsp_start_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_vert_in  = rsp_vert_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.wrap) begin
         rsp_valid_in = 1'b1;
         rsp_start_in = cur_start_ff;
         rsp_bytes_in = saved_bytes_ff;
         rsp_vert_in  = saved_vertices_ff;
         rsp_sw_in    = wrap_sw;
         // Another record follows when the carried word overflows and holds more than one glyph.
         rsp_last_in  = ~((word_x_ff > {8'd0, line_width_ff})
                          && (word_vertices_ff > 17'd2));
      end else if (cmd.brk) begin
         rsp_valid_in = 1'b1;
         rsp_start_in = cur_start_ff;
         rsp_bytes_in = (cur_bytes_ff != 16'd0) ? cur_bytes_ff - 16'd1 : 16'd0;
         rsp_vert_in  = cur_vertices_ff - 17'd2;
         rsp_sw_in    = plain_sw;
         rsp_last_in  = 1'b1;
      end else if (cmd.nl) begin
         rsp_valid_in = 1'b1;
         rsp_start_in = cur_start_ff;
         rsp_bytes_in = cur_bytes_ff;
         rsp_vert_in  = cur_vertices_ff;
         rsp_sw_in    = plain_sw;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff    <= 12'd480;
         space_advance_ff <= 8'd4;
         byte_position_ff <= 16'd0;
         line_open_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         line_width_ff    <= line_width_in;
         space_advance_ff <= space_advance_in;
         byte_position_ff <= byte_position_in;
         line_open_ff     <= line_open_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      char_ff           <= char_in;
      adv_ff            <= adv_in;
      start_ff          <= start_in;
      item_pos_ff       <= item_pos_in;
      cur_start_ff      <= cur_start_in;
      cur_bytes_ff      <= cur_bytes_in;
      cur_vertices_ff   <= cur_vertices_in;
      cur_x_ff          <= cur_x_in;
      space_count_ff    <= space_count_in;
      saved_bytes_ff    <= saved_bytes_in;
      saved_vertices_ff <= saved_vertices_in;
      saved_x_ff        <= saved_x_in;
      word_bytes_ff     <= word_bytes_in;
      word_vertices_ff  <= word_vertices_in;
      word_x_ff         <= word_x_in;
      rsp_start_ff      <= rsp_start_in;
      rsp_bytes_ff      <= rsp_bytes_in;
      rsp_vert_ff       <= rsp_vert_in;
      rsp_sw_ff         <= rsp_sw_in;
      rsp_last_ff       <= rsp_last_in;
   end

   // Status for the controller.
   always_comb begin
      sts.is_nl       = is_nl;
      sts.is_print    = is_print;
      sts.over        = cur_x_ff > {8'd0, line_width_ff};
      sts.has_space   = space_count_ff != 16'd0;
      sts.multi_glyph = cur_vertices_ff > 17'd2;
      sts.slot_free   = slot_free;
      sts.div_busy    = div_busy;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_start     = rsp_start_ff;
   assign rsp_line_bytes     = rsp_bytes_ff;
   assign rsp_vertex_count   = rsp_vert_ff;
   assign rsp_space_width_q8 = rsp_sw_ff;
   assign rsp_last_of_run    = rsp_last_ff;

   // A newline record always leaves the line closed.
   assert property (@(posedge clock) disable iff (reset)
      cmd.nl |=> !line_open_ff)
      else $error("line still open after newline record");

   // A wrap forgets every break point of the old line.
   assert property (@(posedge clock) disable iff (reset)
      cmd.wrap |=> space_count_ff == 16'd0 && saved_x_ff == 20'd0)
      else $error("break point survived a wrap");

endmodule

FILE: rtl/gwwj_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word wrap controller
// Sequences accumulation, break decisions, the division and record output.
// ----------------------------------------------------------------------------
module gwwj_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gwwj_pkg::status_type sts,
   output gwwj_pkg::cmd_type    cmd
);

   gwwj_pkg::state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gwwj_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = gwwj_pkg::ST_ACCUM;
            end
         end
         gwwj_pkg::ST_ACCUM: begin
            state_in = gwwj_pkg::ST_CHECK;
         end
         gwwj_pkg::ST_CHECK: begin
            if (sts.is_nl) begin
               state_in = gwwj_pkg::ST_NEWLINE;
            end else if (sts.is_print && sts.over && sts.has_space) begin
               state_in = gwwj_pkg::ST_DIVIDE;
            end else if (sts.is_print && sts.over && sts.multi_glyph) begin
               state_in = gwwj_pkg::ST_BREAK;
            end else begin
               state_in = gwwj_pkg::ST_IDLE;
            end
         end
         gwwj_pkg::ST_DIVIDE: begin
            if (!sts.div_busy) begin
               state_in = gwwj_pkg::ST_WRAP;
            end
         end
         gwwj_pkg::ST_WRAP: begin
            // Back to the check: the carried word may overflow again.
            if (sts.slot_free) begin
               state_in = gwwj_pkg::ST_CHECK;
            end
         end
         gwwj_pkg::ST_BREAK, gwwj_pkg::ST_NEWLINE: begin
            if (sts.slot_free) begin
               state_in = gwwj_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gwwj_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         gwwj_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         gwwj_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         gwwj_pkg::ST_CHECK: begin
            cmd.div_start = sts.is_print && sts.over && sts.has_space && !sts.is_nl;
         end
         gwwj_pkg::ST_WRAP: begin
            cmd.wrap = sts.slot_free;
         end
         gwwj_pkg::ST_BREAK: begin
            cmd.brk = sts.slot_free;
         end
         gwwj_pkg::ST_NEWLINE: begin
            cmd.nl = sts.slot_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gwwj_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // No record is written over one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.wrap || cmd.brk || cmd.nl) |-> sts.slot_free)
      else $error("record register overwritten");

   // The divider is idle whenever a division is requested.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("division started while divider busy");

   // At most one datapath command per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("conflicting datapath commands");

endmodule

FILE: rtl/greedy_word_wrap_justify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy word wrap with justification
// Splits a byte stream into line records with justified space widths.
// ----------------------------------------------------------------------------
//
//   channel  direction  content
//   req_ch   in         text byte, glyph advance, start-of-text flag
//   rsp_ch   out        line start, byte count, vertex count, space width
//   csr_ch   in         register index and write data (always ready)
//
// An ordinary byte goes through transfer, accumulate and break check.
// A newline or a word broken before its overflowing byte adds the writing of
// the record. A wrap at a space adds the serial division of the slack by the
// gap count, a wait to see the divider finish, the record and a second break
// check; the carried word may still overflow and is then broken as well.
// Reset is synchronous; there is no clearing pass.
// Records wait in a single output register; the block stalls only when it
// must write a record while the previous one has not been transferred.
//
module greedy_word_wrap_justify (
   input  logic       clock,
   input  logic       reset,
   gwwj_req_if.sink   req_ch,
   gwwj_rsp_if.source rsp_ch,
   gwwj_csr_if.sink   csr_ch
);

   gwwj_pkg::cmd_type    cmd;
   gwwj_pkg::status_type sts;

   assign csr_ch.ready = 1'b1;

   gwwj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gwwj_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_char_byte      (req_ch.char_byte),
      .req_char_advance   (req_ch.char_advance),
      .req_text_start     (req_ch.text_start),
      .csr_write          (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_line_start     (rsp_ch.line_start),
      .rsp_line_bytes     (rsp_ch.line_bytes),
      .rsp_vertex_count   (rsp_ch.vertex_count),
      .rsp_space_width_q8 (rsp_ch.space_width_q8),
      .rsp_last_of_run    (rsp_ch.last_of_run)
   );

endmodule

FILE: tb/sv/tb_greedy_word_wrap_justify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word wrap testbench
// Feeds text bytes through the word wrap block with random gaps and stalls,
// works out every line record in a behavioural model of its own and checks
// each record that leaves the block, field by field, in order.
// ----------------------------------------------------------------------------
module tb_greedy_word_wrap_justify;

   localparam int unsigned MAX16      = 65535;
   localparam int unsigned MAX_X      = 20'hFFFFF;
   localparam int          SETTLE     = 40;
   localparam int          IDLE_PCT   = 30;
   localparam int          MAX_PRINTS = 100;

   typedef struct {
      logic [15:0] start;
      logic [15:0] nbytes;
      logic [16:0] verts;
      logic [20:0] space_q8;
      logic        last;
   } line_rec_type;

   logic clock;
   logic reset;
   bit   idle_on;
   int   errors;

   gwwj_req_if req_if();
   gwwj_rsp_if rsp_if();
   gwwj_csr_if csr_if();

   greedy_word_wrap_justify uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Clock with an 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Register copies and line state of the behavioural model.
   logic [11:0]  cfg_line_width;
   logic [7:0]   cfg_space_adv;
   logic         open_line;
   logic [15:0]  text_pos, ln_start, ln_bytes, ln_spaces, brk_bytes, wd_bytes;
   logic [16:0]  ln_verts, brk_verts, wd_verts;
   logic [19:0]  ln_x, brk_x, wd_x;
   line_rec_type pending_lines[$];
   line_rec_type want;

   function automatic int unsigned sat_sum(int unsigned a, int unsigned b,
                                           int unsigned cap);
      return (a + b > cap) ? cap : a + b;
   endfunction

   function automatic void clear_text();
      text_pos  = '0;
      open_line = 1'b0;
      ln_start  = '0;
      ln_bytes  = '0;
      ln_verts  = '0;
      ln_x      = '0;
      ln_spaces = '0;
      brk_bytes = '0;
      brk_verts = '0;
      brk_x     = '0;
      wd_bytes  = '0;
      wd_verts  = '0;
      wd_x      = '0;
   endfunction

   // Works out the line records that one accepted byte closes and queues them.
   task automatic predict_lines(input logic [7:0] ch, input logic [7:0] adv,
                                input logic first);
      line_rec_type recs[$];
      line_rec_type rec;
      logic [15:0]  here;
      logic [20:0]  plain_q8;
      int unsigned  slack, gaps, width_q8;
      if (first) clear_text();
      here     = text_pos;
      plain_q8 = {5'd0, cfg_space_adv, 8'd0};

      // The first byte after a closed line opens a new one.
      if (!open_line) begin
         ln_start  = here;
         ln_bytes  = '0;
         ln_verts  = '0;
         ln_x      = '0;
         ln_spaces = '0;
         brk_bytes = '0;
         brk_verts = '0;
         brk_x     = '0;
         wd_bytes  = '0;
         wd_verts  = '0;
         wd_x      = '0;
         open_line = 1'b1;
      end
      ln_bytes = 16'(sat_sum(ln_bytes, 1, MAX16));

      if (ch == gwwj_pkg::CHAR_SPACE) begin
         // A space remembers the break point and starts a new word.
         brk_x     = ln_x;
         ln_x      = 20'(sat_sum(ln_x, cfg_space_adv, MAX_X));
         brk_bytes = ln_bytes;
         brk_verts = ln_verts;
         ln_spaces = 16'(sat_sum(ln_spaces, 1, MAX16));
         wd_bytes  = '0;
         wd_verts  = '0;
         wd_x      = '0;
      end else if (ch == gwwj_pkg::CHAR_NEWLINE) begin
         rec = '{ln_start, ln_bytes, ln_verts, plain_q8, 1'b0};
         recs.push_back(rec);
         open_line = 1'b0;
      end else if (ch > gwwj_pkg::CHAR_SPACE) begin
         ln_verts = 17'(sat_sum(ln_verts, 2, gwwj_pkg::VERT_MAX));
         ln_x     = 20'(sat_sum(ln_x, adv, MAX_X));
         wd_bytes = 16'(sat_sum(wd_bytes, 1, MAX16));
         wd_verts = 17'(sat_sum(wd_verts, 2, gwwj_pkg::VERT_MAX));
         wd_x     = 20'(sat_sum(wd_x, adv, MAX_X));

         // Overflow with a space on the line: wrap there and spread the slack.
         if (ln_x > cfg_line_width && ln_spaces != 0) begin
            slack    = (cfg_line_width > brk_x)
                       ? 32'(cfg_line_width) - 32'(brk_x) : 0;
            gaps     = ln_spaces - 1;
            width_q8 = 32'(plain_q8);
            if (gaps != 0) width_q8 += (slack << 8) / gaps;
            rec = '{ln_start, brk_bytes, brk_verts, 21'(width_q8), 1'b0};
            recs.push_back(rec);
            ln_start  = 16'(sat_sum(ln_start, brk_bytes, MAX16));
            ln_bytes  = wd_bytes;
            ln_verts  = wd_verts;
            ln_x      = wd_x;
            ln_spaces = '0;
            brk_bytes = '0;
            brk_verts = '0;
            brk_x     = '0;
         end

         // A word wider than the line is broken before this byte, unless the
         // byte is the only glyph on the line.
         if (ln_x > cfg_line_width && ln_spaces == 0 && ln_verts > 2) begin
            rec = '{ln_start, (ln_bytes != 0) ? ln_bytes - 16'd1 : 16'd0,
                    ln_verts - 17'd2, plain_q8, 1'b0};
            recs.push_back(rec);
            ln_start = here;
            ln_bytes = 16'd1;
            ln_verts = 17'd2;
            ln_x     = 20'(adv);
            wd_bytes = 16'd1;
            wd_verts = 17'd2;
            wd_x     = 20'(adv);
         end
      end else begin
         wd_bytes = 16'(sat_sum(wd_bytes, 1, MAX16));
      end

      text_pos = 16'(sat_sum(here, 1, gwwj_pkg::POS_MAX));
      if (recs.size() != 0) recs[recs.size() - 1].last = 1'b1;
      foreach (recs[i]) pending_lines.push_back(recs[i]);
   endtask

   task automatic report_mismatch(input string what, input longint got,
                                  input longint exp_val);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("%0t ns: %s is %0d, expected %0d", $time, what, got, exp_val);
   endtask

   // Result sink: random stalls while idling is on.
   always @(posedge clock) begin
      rsp_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
   end

   // Each record transfer is compared with the oldest expected record.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_lines.size() == 0) begin
            report_mismatch("line record with none pending, line_start",
                            rsp_if.line_start, 0);
         end else begin
            want = pending_lines.pop_front();
            if (rsp_if.line_start !== want.start)
               report_mismatch("line_start", rsp_if.line_start, want.start);
            if (rsp_if.line_bytes !== want.nbytes)
               report_mismatch("line_bytes", rsp_if.line_bytes, want.nbytes);
            if (rsp_if.vertex_count !== want.verts)
               report_mismatch("vertex_count", rsp_if.vertex_count, want.verts);
            if (rsp_if.space_width_q8 !== want.space_q8)
               report_mismatch("space_width_q8", rsp_if.space_width_q8, want.space_q8);
            if (rsp_if.last_of_run !== want.last)
               report_mismatch("last_of_run", rsp_if.last_of_run, want.last);
         end
      end
   end

   // Sends one byte; valid stays high afterwards unless the next call idles.
   task automatic send_char(input logic [7:0] ch, input logic [7:0] adv,
                            input logic first = 1'b0);
      if (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while (idle_on && $urandom_range(99) < IDLE_PCT);
      end
      req_if.valid        <= 1'b1;
      req_if.char_byte    <= ch;
      req_if.char_advance <= adv;
      req_if.text_start   <= first;
      do @(posedge clock); while (!req_if.ready);
      predict_lines(ch, adv, first);
   endtask

   // Holds the sender back until every expected record has been transferred.
   task automatic drain_lines(input int settle);
      req_if.valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Register writes happen only once the block has gone quiet.
   task automatic write_reg(input gwwj_pkg::csr_index_type idx,
                            input logic [gwwj_pkg::CSR_DATA_WIDTH-1:0] value);
      drain_lines(SETTLE);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         gwwj_pkg::CSR_LINE_WIDTH:    cfg_line_width = value;
         gwwj_pkg::CSR_SPACE_ADVANCE: cfg_space_adv  = value[7:0];
         default:                     cfg_space_adv  = cfg_space_adv;
      endcase
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_format(input int width, input int space_adv);
      write_reg(gwwj_pkg::CSR_LINE_WIDTH, 12'(width));
      write_reg(gwwj_pkg::CSR_SPACE_ADVANCE, {4'($urandom), 8'(space_adv)});
   endtask

   // Newline-terminated line with glyph, space and control bytes at reset format.
   task automatic test_plain_lines();
      send_char(8'h41, 8'd255, 1'b1);
      send_char(8'h62, 8'd0);
      send_char(8'h00, 8'd9);
      send_char(8'h1f, 8'd1);
      send_char(gwwj_pkg::CHAR_SPACE, 8'd200);
      send_char(8'hff, 8'd7);
      send_char(gwwj_pkg::CHAR_NEWLINE, 8'd3);
   endtask

   // Justified wrap, word breaks, a byte closing two lines and a lone wide glyph.
   task automatic test_wrapping();
      set_format(10, 3);
      send_char(8'h61, 8'd2, 1'b1);
      send_char(gwwj_pkg::CHAR_SPACE, 8'd0);
      send_char(8'h62, 8'd2);
      send_char(gwwj_pkg::CHAR_SPACE, 8'd0);
      send_char(8'h63, 8'd5);
      send_char(8'h64, 8'd6);
      send_char(8'h65, 8'd20);
      send_char(gwwj_pkg::CHAR_NEWLINE, 8'd0);
      // The carried word still overflows after the wrap; left unterminated.
      send_char(8'h61, 8'd0, 1'b1);
      send_char(gwwj_pkg::CHAR_SPACE, 8'd0);
      send_char(8'h62, 8'd1);
      send_char(8'h63, 8'd10);
      // A new text throws the open line away.
      send_char(8'h58, 8'd200, 1'b1);
      send_char(gwwj_pkg::CHAR_NEWLINE, 8'd0);
   endtask

   // Long runs of wide spaces and glyphs at the widest format, so that the
   // slack of a wrap is clipped to zero and long words break over and over.
   task automatic test_long_runs();
      set_format(4095, 255);
      send_char(gwwj_pkg::CHAR_SPACE, 8'd0, 1'b1);
      repeat (60) send_char(gwwj_pkg::CHAR_SPACE, 8'($urandom));
      send_char(8'h78, 8'd1);
      send_char(gwwj_pkg::CHAR_NEWLINE, 8'd0);
      repeat (120) send_char(8'($urandom_range(33, 255)), 8'($urandom));
      send_char(gwwj_pkg::CHAR_NEWLINE, 8'd0);
   endtask

   // Random text: mostly words and spaces, with newlines, control bytes,
   // new texts, pauses and raw noise mixed in.
   task automatic random_text(input int count);
      int         sent, kind, len, max_adv;
      logic       fresh;
      logic [7:0] ch;
      sent    = 0;
      fresh   = 1'($urandom_range(1));
      max_adv = cfg_line_width / 24;
      if (max_adv < 1) max_adv = 1;
      if (max_adv > 255) max_adv = 255;
      while (sent < count) begin
         kind = $urandom_range(99);
         if (kind < 58) begin
            len = $urandom_range(1, 10);
            repeat (len) begin
               send_char(8'($urandom_range(33, 255)),
                         ($urandom_range(15) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, max_adv)),
                         fresh);
               fresh = 1'b0;
               sent++;
            end
         end else if (kind < 78) begin
            repeat ($urandom_range(1, 2)) begin
               send_char(gwwj_pkg::CHAR_SPACE, 8'($urandom), fresh);
               fresh = 1'b0;
               sent++;
            end
         end else if (kind < 86) begin
            send_char(gwwj_pkg::CHAR_NEWLINE, 8'($urandom), fresh);
            fresh = 1'b0;
            sent++;
         end else if (kind < 91) begin
            do ch = 8'($urandom_range(0, 31)); while (ch == gwwj_pkg::CHAR_NEWLINE);
            send_char(ch, 8'($urandom), fresh);
            fresh = 1'b0;
            sent++;
         end else if (kind < 94) begin
            fresh = 1'b1;
         end else if (kind < 96) begin
            drain_lines(1);
         end else begin
            send_char(8'($urandom), 8'($urandom), fresh | ($urandom_range(15) == 0));
            fresh = 1'b0;
            sent++;
         end
      end
   endtask

   // Random phases over a spread of formats, the extremes among them.
   task automatic test_random_text();
      set_format($urandom_range(40, 200), $urandom_range(1, 8));
      random_text(250);
      set_format(0, 255);
      random_text(150);
      set_format(4095, 0);
      random_text(200);
      idle_on = 1'b0;
      set_format($urandom_range(60, 300), $urandom_range(0, 16));
      random_text(250);
      idle_on = 1'b1;
      set_format(4095, 255);
      random_text(200);
      set_format($urandom_range(8, 64), $urandom_range(0, 20));
      random_text(200);
      set_format($urandom_range(0, 4095), $urandom_range(0, 255));
      random_text(200);
   endtask

   // Test sequence.
   initial begin
      errors              = 0;
      idle_on             = 1'b1;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.char_byte    <= '0;
      req_if.char_advance <= '0;
      req_if.text_start   <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= gwwj_pkg::CSR_LINE_WIDTH;
      csr_if.data         <= '0;
      cfg_line_width      = 12'd480;
      cfg_space_adv       = 8'd4;
      clear_text();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_plain_lines();
      test_wrapping();
      idle_on = 1'b0;
      test_long_runs();
      idle_on = 1'b1;
      test_random_text();

      drain_lines(SETTLE);
      if (errors == 0)
         $display("PASS greedy_word_wrap_justify");
      else
         $display("FAIL greedy_word_wrap_justify");
      $finish;
   end

   // Watchdog.
   initial begin
      #40ms;
      $display("FAIL greedy_word_wrap_justify");
      $finish;
   end

endmodule
